// ===== hdl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg: shared widths, constants and tables for the rotator
// Fixed-point formats, CORDIC arctangent table and default parameter values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arp_pkg;

   // Field and datapath widths.
   localparam int DATA_W     = 32;
   localparam int EPS_W      = 31;
   localparam int CORDIC_W   = 34;
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_REM_W = 36;
   localparam int DIV_REM_W  = 34;
   localparam int QUOT_W     = 31;

   // Defaults for the top-level parameters.
   localparam int CORDIC_STAGES_DEF = 24;
   localparam int COORD_WIDTH_DEF   = 32;

   localparam logic [EPS_W-1:0] EPS_RESET = 31'd1;

   // Angle constants in Q4.28 and CORDIC constants in Q2.30.
   localparam logic signed [CORDIC_W-1:0] PI_Q28      = 34'sd843314857;
   localparam logic signed [CORDIC_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] Q30_ONE     = 34'sd1073741824;

   // Truncated arctangent of 2^-idx in Q2.30.
   function automatic logic [31:0] atan_q30(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'h3243F6A8;
         1:  v = 32'h1DAC6705;
         2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;
         4:  v = 32'h03FEAB76;
         5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;
         7:  v = 32'h007FFF55;
         8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;
         10: v = 32'h000FFFFF;
         11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;
         13: v = 32'h0001FFFF;
         14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;
         16: v = 32'h00003FFF;
         17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;
         19: v = 32'h000007FF;
         20: v = 32'h000003FF;
         21: v = 32'h000001FF;
         22: v = 32'h000000FF;
         23: v = 32'h0000007F;
         24: v = 32'h0000003F;
         25: v = 32'h0000001F;
         26: v = 32'h0000000F;
         27: v = 32'h00000008;
         28: v = 32'h00000004;
         29: v = 32'h00000002;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/arp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// arp_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates (x, y) by plus or minus atan(2^-STAGE), steered by the sign of z.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cordic_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [arp_pkg::CORDIC_W-1:0]  x_in,
   input  logic signed [arp_pkg::CORDIC_W-1:0]  y_in,
   input  logic signed [arp_pkg::CORDIC_W-1:0]  z_in,
   input  logic [SIDE_W-1:0]                    side_in,
   output logic                                 out_valid,
   output logic signed [arp_pkg::CORDIC_W-1:0]  x_out,
   output logic signed [arp_pkg::CORDIC_W-1:0]  y_out,
   output logic signed [arp_pkg::CORDIC_W-1:0]  z_out,
   output logic [SIDE_W-1:0]                    side_out
);

   localparam logic signed [arp_pkg::CORDIC_W-1:0] ATAN =
      {2'b00, arp_pkg::atan_q30(STAGE)};

   logic                                valid_ff;
   logic signed [arp_pkg::CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic signed [arp_pkg::CORDIC_W-1:0] x_in_c, y_in_c, z_in_c;
   logic [SIDE_W-1:0]                   side_ff;

   // Micro-rotation with flooring shifts.
   always_comb begin
      if (!z_in[arp_pkg::CORDIC_W-1]) begin
         x_in_c = x_in - (y_in >>> STAGE);
         y_in_c = y_in + (x_in >>> STAGE);
         z_in_c = z_in - ATAN;
      end else begin
         x_in_c = x_in + (y_in >>> STAGE);
         y_in_c = y_in - (x_in >>> STAGE);
         z_in_c = z_in + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in_c;
         y_ff    <= y_in_c;
         z_ff    <= z_in_c;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

endmodule

// ===== hdl/arp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// arp_sqrt_cell: one digit of a restoring integer square root
// Brings in two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_sqrt_cell #(
   parameter int BIT_POS = 0,
   parameter int SIDE_W  = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [arp_pkg::RAD_W-1:0]          rad_in,
   input  logic [arp_pkg::SQRT_REM_W-1:0]     rem_in,
   input  logic [arp_pkg::ROOT_W-1:0]         root_in,
   input  logic [SIDE_W-1:0]                  side_in,
   output logic                               out_valid,
   output logic [arp_pkg::RAD_W-1:0]          rad_out,
   output logic [arp_pkg::SQRT_REM_W-1:0]     rem_out,
   output logic [arp_pkg::ROOT_W-1:0]         root_out,
   output logic [SIDE_W-1:0]                  side_out
);

   localparam int PAD_W = arp_pkg::SQRT_REM_W - arp_pkg::ROOT_W - 2;

   logic                             valid_ff;
   logic [arp_pkg::RAD_W-1:0]        rad_ff;
   logic [arp_pkg::SQRT_REM_W-1:0]   rem_ff;
   logic [arp_pkg::ROOT_W-1:0]       root_ff;
   logic [SIDE_W-1:0]                side_ff;
   logic [arp_pkg::SQRT_REM_W-1:0]   rem_shift_c, trial_c, rem_next_c;
   logic                             ge_c;

   // Trial subtraction of 4*root + 1 from the shifted remainder.
   always_comb begin
      rem_shift_c = {rem_in[arp_pkg::SQRT_REM_W-3:0], rad_in[2*BIT_POS+1 -: 2]};
      trial_c     = {{PAD_W{1'b0}}, root_in, 2'b01};
      ge_c        = (rem_shift_c >= trial_c);
      rem_next_c  = ge_c ? (rem_shift_c - trial_c) : rem_shift_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_next_c;
         root_ff <= {root_in[arp_pkg::ROOT_W-2:0], ge_c};
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign side_out  = side_ff;

endmodule

// ===== hdl/arp_div_cell.sv =====
// ----------------------------------------------------------------------------
// arp_div_cell: one quotient bit of three restoring divisions
// All three axis components share one divisor, the axis length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_div_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [2:0][arp_pkg::DIV_REM_W-1:0]      rem_in,
   input  logic [2:0][arp_pkg::QUOT_W-1:0]         quot_in,
   input  logic [arp_pkg::ROOT_W-1:0]              len_in,
   input  logic [SIDE_W-1:0]                       side_in,
   output logic                                    out_valid,
   output logic [2:0][arp_pkg::DIV_REM_W-1:0]      rem_out,
   output logic [2:0][arp_pkg::QUOT_W-1:0]         quot_out,
   output logic [arp_pkg::ROOT_W-1:0]              len_out,
   output logic [SIDE_W-1:0]                       side_out
);

   localparam int DIFF_W = arp_pkg::DIV_REM_W + 1;

   logic                                 valid_ff;
   logic [2:0][arp_pkg::DIV_REM_W-1:0]   rem_ff, rem_next_c;
   logic [2:0][arp_pkg::QUOT_W-1:0]      quot_ff, quot_next_c;
   logic [arp_pkg::ROOT_W-1:0]           len_ff;
   logic [SIDE_W-1:0]                    side_ff;

   // Compare each remainder with the divisor and shift for the next bit.
   always_comb begin
      logic [DIFF_W-1:0]             diff;
      logic [arp_pkg::DIV_REM_W-1:0] kept;
      logic                          ge;
      for (int i = 0; i < 3; i++) begin
         diff = {1'b0, rem_in[i]} - {{(DIFF_W-arp_pkg::ROOT_W){1'b0}}, len_in};
         ge   = !diff[DIFF_W-1];
         kept = ge ? diff[arp_pkg::DIV_REM_W-1:0] : rem_in[i];
         rem_next_c[i]  = {kept[arp_pkg::DIV_REM_W-2:0], 1'b0};
         quot_next_c[i] = {quot_in[i][arp_pkg::QUOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_next_c;
         quot_ff <= quot_next_c;
         len_ff  <= len_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign rem_out   = rem_ff;
   assign quot_out  = quot_ff;
   assign len_out   = len_ff;
   assign side_out  = side_ff;

endmodule

// ===== hdl/axis_angle_point_rotator_core.sv =====
// ----------------------------------------------------------------------------
// axis_angle_point_rotator_core: Rodrigues rotation of a point about an axis
// Throughput is one item per cycle; the chain holds only while both the
// output register and its skid register are full. Depth is set by the front
// stages, the CORDIC cells, 32 square-root cells, 31 divider cells and the
// rotation stages. Synchronous reset empties the chain and sets the epsilon
// register to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_point_rotator_core #(
   parameter int CORDIC_STAGES = arp_pkg::CORDIC_STAGES_DEF,
   parameter int COORD_WIDTH   = arp_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // point_x, point_y, point_z, axis_x, axis_y, axis_z, turn_angle
   input  logic [223:0]                 req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_x, out_y, out_z
   output logic [95:0]                  rsp_tdata,
   // saturated, axis_degenerate
   output logic [1:0]                   rsp_tuser,
   input  logic                         csr_wr_en,
   input  logic [arp_pkg::EPS_W-1:0]    csr_wr_data
);

   localparam int SAT_W  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int CW     = arp_pkg::CORDIC_W;
   localparam int N_SQRT = arp_pkg::ROOT_W;
   localparam int N_DIV  = arp_pkg::QUOT_W;
   localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (SAT_W - 1)) - 40'sd1;
   localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

   typedef struct packed {
      logic [2:0][31:0] pt;
      logic [2:0]       sgn;
      logic             skip;
      logic             deg;
      logic             neg;
      logic [2:0][31:0] msh;
      logic [63:0]      sum;
   } cside_type;

   typedef struct packed {
      logic [2:0][31:0] pt;
      logic [2:0]       sgn;
      logic             skip;
      logic             deg;
      logic             neg;
      logic [2:0][31:0] msh;
      logic [CW-1:0]    cx;
      logic [CW-1:0]    cy;
   } sside_type;

   typedef struct packed {
      logic [2:0][31:0] pt;
      logic [2:0]       sgn;
      logic             skip;
      logic             deg;
      logic             neg;
      logic [CW-1:0]    cx;
      logic [CW-1:0]    cy;
   } dside_type;

   typedef struct packed {
      logic [2:0][31:0] coord;
      logic             sat;
      logic             deg;
   } out_type;

   localparam int CSIDE_W = $bits(cside_type);
   localparam int SSIDE_W = $bits(sside_type);
   localparam int DSIDE_W = $bits(dside_type);

   // Normalizing shift: moves the largest magnitude to at least 2^30.
   function automatic logic [4:0] norm_shift(input logic [31:0] v);
      logic [4:0] s;
      s = 5'd0;
      for (int b = 0; b < 30; b++) begin
         if (v[b]) begin
            s = 5'(30 - b);
         end
      end
      if (v[31:30] != 2'b00) begin
         s = 5'd0;
      end
      return s;
   endfunction

   logic                   en;
   logic [arp_pkg::EPS_W-1:0] eps_ff;

   // Epsilon register.
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= arp_pkg::EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- front
   logic             s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic [2:0][31:0] s1_pt_ff, s1_ax_ff;
   logic [31:0]      s1_ang_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_pt_ff[i] <= req_tdata[32*i +: 32];
            s1_ax_ff[i] <= req_tdata[96 + 32*i +: 32];
         end
         s1_ang_ff <= req_tdata[223:192];
      end
   end

   // Stage 2: magnitudes, epsilon test and wrap by 2*pi.
   logic [2:0][31:0] s2_pt_ff, s2_m_ff;
   logic [2:0]       s2_sgn_ff;
   logic             s2_skip_ff;
   logic [31:0]      s2_ang_ff;
   logic [2:0][31:0] s2_m_c;
   logic [31:0]      s2_mag_c;
   logic signed [CW-1:0] s2_ext_c, s2_wrap_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_m_c[i] = s1_ax_ff[i][31] ? (~s1_ax_ff[i] + 32'd1) : s1_ax_ff[i];
      end
      s2_mag_c = s1_ang_ff[31] ? (~s1_ang_ff + 32'd1) : s1_ang_ff;
      s2_ext_c = {{2{s1_ang_ff[31]}}, s1_ang_ff};
      if (s2_ext_c > arp_pkg::PI_Q28) begin
         s2_wrap_c = s2_ext_c - arp_pkg::TWO_PI_Q28;
      end else if (s2_ext_c < -arp_pkg::PI_Q28) begin
         s2_wrap_c = s2_ext_c + arp_pkg::TWO_PI_Q28;
      end else begin
         s2_wrap_c = s2_ext_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pt_ff   <= s1_pt_ff;
         s2_m_ff    <= s2_m_c;
         s2_sgn_ff  <= {s1_ax_ff[2][31], s1_ax_ff[1][31], s1_ax_ff[0][31]};
         s2_skip_ff <= (s2_mag_c <= {1'b0, eps_ff});
         s2_ang_ff  <= s2_wrap_c[31:0];
      end
   end

   // Stage 3: largest magnitude and fold into the right half plane.
   logic [2:0][31:0]     s3_pt_ff, s3_m_ff;
   logic [2:0]           s3_sgn_ff;
   logic                 s3_skip_ff, s3_deg_ff, s3_neg_ff;
   logic [31:0]          s3_mx_ff;
   logic signed [CW-1:0] s3_z_ff;
   logic [31:0]          s3_mx_c;
   logic signed [CW-1:0] s3_ext_c, s3_fold_c;
   logic                 s3_neg_c;

   always_comb begin
      s3_mx_c = s2_m_ff[0];
      if (s2_m_ff[1] > s3_mx_c) begin
         s3_mx_c = s2_m_ff[1];
      end
      if (s2_m_ff[2] > s3_mx_c) begin
         s3_mx_c = s2_m_ff[2];
      end
      s3_ext_c = {{2{s2_ang_ff[31]}}, s2_ang_ff};
      s3_neg_c = 1'b0;
      if (s3_ext_c > arp_pkg::HALF_PI_Q28) begin
         s3_fold_c = s3_ext_c - arp_pkg::PI_Q28;
         s3_neg_c  = 1'b1;
      end else if (s3_ext_c < -arp_pkg::HALF_PI_Q28) begin
         s3_fold_c = s3_ext_c + arp_pkg::PI_Q28;
         s3_neg_c  = 1'b1;
      end else begin
         s3_fold_c = s3_ext_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pt_ff   <= s2_pt_ff;
         s3_m_ff    <= s2_m_ff;
         s3_sgn_ff  <= s2_sgn_ff;
         s3_skip_ff <= s2_skip_ff;
         s3_deg_ff  <= (s3_mx_c == 32'd0);
         s3_neg_ff  <= s3_neg_c;
         s3_mx_ff   <= s3_mx_c;
         s3_z_ff    <= {s3_fold_c[31:0], 2'b00};
      end
   end

   // Stage 4: normalizing shift amount.
   logic [2:0][31:0]     s4_pt_ff, s4_m_ff;
   logic [2:0]           s4_sgn_ff;
   logic                 s4_skip_ff, s4_deg_ff, s4_neg_ff;
   logic signed [CW-1:0] s4_z_ff;
   logic [4:0]           s4_sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_pt_ff   <= s3_pt_ff;
         s4_m_ff    <= s3_m_ff;
         s4_sgn_ff  <= s3_sgn_ff;
         s4_skip_ff <= s3_skip_ff;
         s4_deg_ff  <= s3_deg_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_z_ff    <= s3_z_ff;
         s4_sh_ff   <= norm_shift(s3_mx_ff);
      end
   end

   // Stage 5: shift the magnitudes together.
   logic [2:0][31:0]     s5_pt_ff, s5_msh_ff;
   logic [2:0]           s5_sgn_ff;
   logic                 s5_skip_ff, s5_deg_ff, s5_neg_ff;
   logic signed [CW-1:0] s5_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_pt_ff   <= s4_pt_ff;
         for (int i = 0; i < 3; i++) begin
            s5_msh_ff[i] <= s4_m_ff[i] << s4_sh_ff;
         end
         s5_sgn_ff  <= s4_sgn_ff;
         s5_skip_ff <= s4_skip_ff;
         s5_deg_ff  <= s4_deg_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_z_ff    <= s4_z_ff;
      end
   end

   // Stage 6: squares of the normalized components.
   logic [2:0][31:0]     s6_pt_ff, s6_msh_ff;
   logic [2:0][63:0]     s6_sq_ff;
   logic [2:0]           s6_sgn_ff;
   logic                 s6_skip_ff, s6_deg_ff, s6_neg_ff;
   logic signed [CW-1:0] s6_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_pt_ff  <= s5_pt_ff;
         s6_msh_ff <= s5_msh_ff;
         for (int i = 0; i < 3; i++) begin
            s6_sq_ff[i] <= 64'(s5_msh_ff[i]) * 64'(s5_msh_ff[i]);
         end
         s6_sgn_ff  <= s5_sgn_ff;
         s6_skip_ff <= s5_skip_ff;
         s6_deg_ff  <= s5_deg_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_z_ff    <= s5_z_ff;
      end
   end

   // Stage 7: sum of squares.
   cside_type            s7_side_ff;
   logic signed [CW-1:0] s7_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_side_ff.pt   <= s6_pt_ff;
         s7_side_ff.sgn  <= s6_sgn_ff;
         s7_side_ff.skip <= s6_skip_ff;
         s7_side_ff.deg  <= s6_deg_ff;
         s7_side_ff.neg  <= s6_neg_ff;
         s7_side_ff.msh  <= s6_msh_ff;
         s7_side_ff.sum  <= s6_sq_ff[0] + s6_sq_ff[1] + s6_sq_ff[2];
         s7_z_ff         <= s6_z_ff;
      end
   end

   // ---------------------------------------------------------------- CORDIC
   logic                 c_v    [0:CORDIC_STAGES];
   logic signed [CW-1:0] c_x    [0:CORDIC_STAGES];
   logic signed [CW-1:0] c_y    [0:CORDIC_STAGES];
   logic signed [CW-1:0] c_z    [0:CORDIC_STAGES];
   logic [CSIDE_W-1:0]   c_side [0:CORDIC_STAGES];

   assign c_v[0]    = s7_v_ff;
   assign c_x[0]    = arp_pkg::GAIN_Q30;
   assign c_y[0]    = '0;
   assign c_z[0]    = s7_z_ff;
   assign c_side[0] = s7_side_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      arp_cordic_cell #(
         .STAGE  (g),
         .SIDE_W (CSIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c_v[g]),
         .x_in      (c_x[g]),
         .y_in      (c_y[g]),
         .z_in      (c_z[g]),
         .side_in   (c_side[g]),
         .out_valid (c_v[g+1]),
         .x_out     (c_x[g+1]),
         .y_out     (c_y[g+1]),
         .z_out     (c_z[g+1]),
         .side_out  (c_side[g+1])
      );
   end

   // ----------------------------------------------------------- square root
   cside_type c_end;
   sside_type sq_first;

   always_comb begin
      c_end = cside_type'(c_side[CORDIC_STAGES]);
      sq_first.pt   = c_end.pt;
      sq_first.sgn  = c_end.sgn;
      sq_first.skip = c_end.skip;
      sq_first.deg  = c_end.deg;
      sq_first.neg  = c_end.neg;
      sq_first.msh  = c_end.msh;
      sq_first.cx   = c_x[CORDIC_STAGES];
      sq_first.cy   = c_y[CORDIC_STAGES];
   end

   logic                              q_v    [0:N_SQRT];
   logic [arp_pkg::RAD_W-1:0]         q_rad  [0:N_SQRT];
   logic [arp_pkg::SQRT_REM_W-1:0]    q_rem  [0:N_SQRT];
   logic [arp_pkg::ROOT_W-1:0]        q_root [0:N_SQRT];
   logic [SSIDE_W-1:0]                q_side [0:N_SQRT];

   assign q_v[0]    = c_v[CORDIC_STAGES];
   assign q_rad[0]  = c_end.sum;
   assign q_rem[0]  = '0;
   assign q_root[0] = '0;
   assign q_side[0] = sq_first;

   for (genvar g = 0; g < N_SQRT; g++) begin : g_sqrt
      arp_sqrt_cell #(
         .BIT_POS (N_SQRT - 1 - g),
         .SIDE_W  (SSIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (q_v[g]),
         .rad_in    (q_rad[g]),
         .rem_in    (q_rem[g]),
         .root_in   (q_root[g]),
         .side_in   (q_side[g]),
         .out_valid (q_v[g+1]),
         .rad_out   (q_rad[g+1]),
         .rem_out   (q_rem[g+1]),
         .root_out  (q_root[g+1]),
         .side_out  (q_side[g+1])
      );
   end

   // ---------------------------------------------------------------- divide
   sside_type q_end;
   dside_type dv_first;
   logic [2:0][arp_pkg::DIV_REM_W-1:0] dv_rem_first;

   always_comb begin
      q_end = sside_type'(q_side[N_SQRT]);
      dv_first.pt   = q_end.pt;
      dv_first.sgn  = q_end.sgn;
      dv_first.skip = q_end.skip;
      dv_first.deg  = q_end.deg;
      dv_first.neg  = q_end.neg;
      dv_first.cx   = q_end.cx;
      dv_first.cy   = q_end.cy;
      for (int i = 0; i < 3; i++) begin
         dv_rem_first[i] = {2'b00, q_end.msh[i]};
      end
   end

   logic                                 d_v    [0:N_DIV];
   logic [2:0][arp_pkg::DIV_REM_W-1:0]   d_rem  [0:N_DIV];
   logic [2:0][arp_pkg::QUOT_W-1:0]      d_quot [0:N_DIV];
   logic [arp_pkg::ROOT_W-1:0]           d_len  [0:N_DIV];
   logic [DSIDE_W-1:0]                   d_side [0:N_DIV];

   assign d_v[0]    = q_v[N_SQRT];
   assign d_rem[0]  = dv_rem_first;
   assign d_quot[0] = '0;
   assign d_len[0]  = q_root[N_SQRT];
   assign d_side[0] = dv_first;

   for (genvar g = 0; g < N_DIV; g++) begin : g_div
      arp_div_cell #(
         .SIDE_W (DSIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (d_v[g]),
         .rem_in    (d_rem[g]),
         .quot_in   (d_quot[g]),
         .len_in    (d_len[g]),
         .side_in   (d_side[g]),
         .out_valid (d_v[g+1]),
         .rem_out   (d_rem[g+1]),
         .quot_out  (d_quot[g+1]),
         .len_out   (d_len[g+1]),
         .side_out  (d_side[g+1])
      );
   end

   // ------------------------------------------------------------ rotation
   dside_type d_end;
   assign d_end = dside_type'(d_side[N_DIV]);

   logic                 p0_v_ff, p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic                 p0_skip_ff, p1_skip_ff, p2_skip_ff, p3_skip_ff, p4_skip_ff, p5_skip_ff;
   logic                 p0_deg_ff, p1_deg_ff, p2_deg_ff, p3_deg_ff, p4_deg_ff, p5_deg_ff;
   logic signed [31:0]   p0_pt_ff [3], p1_pt_ff [3], p2_pt_ff [3];
   logic signed [31:0]   p3_pt_ff [3], p4_pt_ff [3], p5_pt_ff [3];
   logic signed [31:0]   p0_k_ff [3], p1_k_ff [3], p2_k_ff [3];
   logic signed [CW-1:0] p0_sn_ff, p1_sn_ff, p2_sn_ff, p3_sn_ff, p4_sn_ff;
   logic signed [CW-1:0] p0_omc_ff, p1_omc_ff, p2_omc_ff, p3_omc_ff, p4_omc_ff;
   logic signed [63:0]   p1_pa_ff [3], p1_pb_ff [3];
   logic signed [33:0]   p2_c1_ff [3], p3_c1_ff [3], p4_c1_ff [3];
   logic signed [65:0]   p3_qa_ff [3], p3_qb_ff [3];
   logic signed [33:0]   p4_c2_ff [3];
   logic signed [67:0]   p5_t1_ff [3], p5_t2_ff [3];

   // Valid bits of the rotation stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else if (en) begin
         p0_v_ff <= d_v[N_DIV];
         p1_v_ff <= p0_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
   end

   // Signed unit axis, final sine and 1 - cosine.
   logic signed [31:0]   p0_k_c [3];
   logic signed [CW-1:0] p0_sn_c, p0_cs_c;

   always_comb begin
      logic [31:0] q;
      for (int i = 0; i < 3; i++) begin
         q         = {1'b0, d_quot[N_DIV][i]};
         p0_k_c[i] = d_end.sgn[i] ? (~q + 32'd1) : q;
      end
      p0_sn_c = d_end.neg ? -$signed(d_end.cy) : $signed(d_end.cy);
      p0_cs_c = d_end.neg ? -$signed(d_end.cx) : $signed(d_end.cx);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p0_pt_ff[i] <= d_end.pt[i];
            p0_k_ff[i]  <= p0_k_c[i];
         end
         p0_skip_ff <= d_end.skip;
         p0_deg_ff  <= d_end.deg;
         p0_sn_ff   <= p0_sn_c;
         p0_omc_ff  <= arp_pkg::Q30_ONE - p0_cs_c;
      end
   end

   // Partial products of k x p.
   always_ff @(posedge clock) begin
      if (en) begin
         p1_pa_ff[0] <= 64'(p0_k_ff[1]) * 64'(p0_pt_ff[2]);
         p1_pb_ff[0] <= 64'(p0_k_ff[2]) * 64'(p0_pt_ff[1]);
         p1_pa_ff[1] <= 64'(p0_k_ff[2]) * 64'(p0_pt_ff[0]);
         p1_pb_ff[1] <= 64'(p0_k_ff[0]) * 64'(p0_pt_ff[2]);
         p1_pa_ff[2] <= 64'(p0_k_ff[0]) * 64'(p0_pt_ff[1]);
         p1_pb_ff[2] <= 64'(p0_k_ff[1]) * 64'(p0_pt_ff[0]);
         p1_pt_ff   <= p0_pt_ff;
         p1_k_ff    <= p0_k_ff;
         p1_skip_ff <= p0_skip_ff;
         p1_deg_ff  <= p0_deg_ff;
         p1_sn_ff   <= p0_sn_ff;
         p1_omc_ff  <= p0_omc_ff;
      end
   end

   // First cross product, floored back to Q16.16.
   always_ff @(posedge clock) begin
      logic signed [64:0] d;
      logic signed [64:0] dsh;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d   = {p1_pa_ff[i][63], p1_pa_ff[i]} - {p1_pb_ff[i][63], p1_pb_ff[i]};
            dsh = d >>> 30;
            p2_c1_ff[i] <= dsh[33:0];
         end
         p2_pt_ff   <= p1_pt_ff;
         p2_k_ff    <= p1_k_ff;
         p2_skip_ff <= p1_skip_ff;
         p2_deg_ff  <= p1_deg_ff;
         p2_sn_ff   <= p1_sn_ff;
         p2_omc_ff  <= p1_omc_ff;
      end
   end

   // Partial products of k x c1.
   always_ff @(posedge clock) begin
      if (en) begin
         p3_qa_ff[0] <= 66'(p2_k_ff[1]) * 66'(p2_c1_ff[2]);
         p3_qb_ff[0] <= 66'(p2_k_ff[2]) * 66'(p2_c1_ff[1]);
         p3_qa_ff[1] <= 66'(p2_k_ff[2]) * 66'(p2_c1_ff[0]);
         p3_qb_ff[1] <= 66'(p2_k_ff[0]) * 66'(p2_c1_ff[2]);
         p3_qa_ff[2] <= 66'(p2_k_ff[0]) * 66'(p2_c1_ff[1]);
         p3_qb_ff[2] <= 66'(p2_k_ff[1]) * 66'(p2_c1_ff[0]);
         p3_c1_ff   <= p2_c1_ff;
         p3_pt_ff   <= p2_pt_ff;
         p3_skip_ff <= p2_skip_ff;
         p3_deg_ff  <= p2_deg_ff;
         p3_sn_ff   <= p2_sn_ff;
         p3_omc_ff  <= p2_omc_ff;
      end
   end

   // Second cross product.
   always_ff @(posedge clock) begin
      logic signed [66:0] d;
      logic signed [66:0] dsh;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d   = {p3_qa_ff[i][65], p3_qa_ff[i]} - {p3_qb_ff[i][65], p3_qb_ff[i]};
            dsh = d >>> 30;
            p4_c2_ff[i] <= dsh[33:0];
         end
         p4_c1_ff   <= p3_c1_ff;
         p4_pt_ff   <= p3_pt_ff;
         p4_skip_ff <= p3_skip_ff;
         p4_deg_ff  <= p3_deg_ff;
         p4_sn_ff   <= p3_sn_ff;
         p4_omc_ff  <= p3_omc_ff;
      end
   end

   // Scale the cross products by sine and 1 - cosine.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p5_t1_ff[i] <= 68'(p4_sn_ff) * 68'(p4_c1_ff[i]);
            p5_t2_ff[i] <= 68'(p4_omc_ff) * 68'(p4_c2_ff[i]);
         end
         p5_pt_ff   <= p4_pt_ff;
         p5_skip_ff <= p4_skip_ff;
         p5_deg_ff  <= p4_deg_ff;
      end
   end

   // Final sum, pass-through select and saturation.
   out_type pipe_out_c;

   always_comb begin
      logic signed [67:0] t1, t2;
      logic signed [39:0] ptx, r, sel;
      pipe_out_c.sat = 1'b0;
      pipe_out_c.deg = p5_deg_ff & ~p5_skip_ff;
      for (int i = 0; i < 3; i++) begin
         t1  = p5_t1_ff[i] >>> 30;
         t2  = p5_t2_ff[i] >>> 30;
         ptx = {{8{p5_pt_ff[i][31]}}, p5_pt_ff[i]};
         r   = ptx + t1[39:0] + t2[39:0];
         sel = (p5_skip_ff || p5_deg_ff) ? ptx : r;
         if (sel > SAT_HI) begin
            sel            = SAT_HI;
            pipe_out_c.sat = 1'b1;
         end else if (sel < SAT_LO) begin
            sel            = SAT_LO;
            pipe_out_c.sat = 1'b1;
         end
         pipe_out_c.coord[i] = sel[31:0];
      end
   end

   // ------------------------------------------------------- output + skid
   out_type out_ff, skid_ff;
   logic    out_v_ff, skid_v_ff;
   logic    take;

   assign en   = !skid_v_ff;
   assign take = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || take) begin
         out_v_ff <= p5_v_ff;
      end else if (p5_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_v_ff || take) begin
         out_ff <= pipe_out_c;
      end else begin
         skid_ff <= pipe_out_c;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.coord[2], out_ff.coord[1], out_ff.coord[0]};
   assign rsp_tuser  = {out_ff.deg, out_ff.sat};

endmodule
